// File: hw/rtl/peer_address_table_defines.svh
// Assertion macros shared by the peer address table RTL.
// Depends on a clk and rst signal in the scope of each use.
`ifndef PEER_ADDRESS_TABLE_DEFINES_SVH
`define PEER_ADDRESS_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pat_pkg.sv
// Types and constants of the peer address table.
// No dependencies; imported by every module of the block.
package pat_pkg;

  localparam int DEPTH   = 8;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [7:0] NO_STRENGTH = -8'sd128;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_APPENDED  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_START,
    B_SCAN,
    B_SHIFT,
    B_RESP
  } back_state_t;

  // one command on its way from the front to the back
  typedef struct packed {
    cmd_t              op;
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic              host;
    logic [31:0]       time_ms;
  } item_t;

  // one table slot
  typedef struct packed {
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic [31:0]       seen;
    logic              host;
  } entry_t;

  // one response
  typedef struct packed {
    status_t           status;
    logic              found;
    logic signed [7:0] strength;
    logic              host;
    logic [31:0]       seen;
    logic [3:0]        count;
  } result_t;

endpackage

// File: hw/rtl/pat_front.sv
// Front end: takes command items, decodes the opcode, holds them in one register.
// Depends on pat_pkg.
module pat_front import pat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        command,
  input  logic [47:0]       peer_address,
  input  logic signed [7:0] signal_strength,
  input  logic              host_flag,
  input  logic [31:0]       time_ms,
  output logic              f_valid,
  input  logic              f_ready,
  output item_t             f_item
);

  item_t decoded;

  // decode the opcode and pack the fields
  always_comb begin
    decoded.op       = cmd_t'(command);
    decoded.addr     = peer_address;
    decoded.strength = signal_strength;
    decoded.host     = host_flag;
    decoded.time_ms  = time_ms;
  end

  // take a new item whenever the register is empty or drains this cycle
  assign cmd_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (cmd_ready) begin
      f_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      f_item <= decoded;
    end
  end

endmodule

// File: hw/rtl/pat_queue.sv
// Short command queue between the front end and the table engine.
// Depends on pat_pkg.
module pat_queue import pat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hw/rtl/pat_back.sv
// Table engine: scans the slot memory, updates, appends, removes with shift-down.
// Depends on pat_pkg.
module pat_back import pat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output result_t rsp
);

  back_state_t      state;
  back_state_t      state_next;
  item_t            item;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  result_t          res;
  result_t          res_next;
  result_t          rsp_load;

  // slot memory: one write and one registered read port
  entry_t           mem [DEPTH];
  entry_t           rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;

  logic             rsp_free;
  logic             load_rsp;
  logic             cnt_zero;
  logic             room;
  logic             hit;
  logic             more_scan;
  logic             more_shift;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W:0]   idx_inc2;
  logic             is_clear;
  logic             miss_append;
  result_t          miss_res;
  result_t          hit_res;
  result_t          clear_res;
  entry_t           new_entry;
  entry_t           upd_entry;

  // conditions
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign cnt_zero   = count == '0;
  assign room       = count < CNT_W'(DEPTH);
  assign hit        = rd_data.addr == item.addr;
  assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
  assign idx_inc2   = (CNT_W + 1)'(idx) + (CNT_W + 1)'(2);
  assign more_scan  = idx_inc < count;
  assign more_shift = idx_inc2 < (CNT_W + 1)'(count);
  assign is_clear   = item.op == CMD_CLEAR;

  // entries written by add
  always_comb begin
    new_entry.addr     = item.addr;
    new_entry.strength = item.strength;
    new_entry.seen     = item.time_ms;
    new_entry.host     = item.host;
    upd_entry          = rd_data;
    upd_entry.strength = item.strength;
    upd_entry.seen     = item.time_ms;
  end

  // candidate responses; count is filled when the response is loaded
  always_comb begin
    miss_append = (item.op == CMD_ADD) && room;

    miss_res.found = 1'b0;
    miss_res.count = '0;
    if (item.op == CMD_ADD) begin
      miss_res.status = room ? STAT_APPENDED : STAT_FULL;
    end else begin
      miss_res.status = STAT_NOT_FOUND;
    end
    if (miss_append) begin
      miss_res.strength = item.strength;
      miss_res.host     = item.host;
      miss_res.seen     = item.time_ms;
    end else begin
      miss_res.strength = NO_STRENGTH;
      miss_res.host     = 1'b0;
      miss_res.seen     = '0;
    end

    hit_res.status   = STAT_OK;
    hit_res.found    = 1'b1;
    hit_res.host     = rd_data.host;
    hit_res.count    = '0;
    if (item.op == CMD_ADD) begin
      hit_res.strength = item.strength;
      hit_res.seen     = item.time_ms;
    end else begin
      hit_res.strength = rd_data.strength;
      hit_res.seen     = rd_data.seen;
    end

    clear_res.status   = STAT_OK;
    clear_res.found    = 1'b0;
    clear_res.strength = NO_STRENGTH;
    clear_res.host     = 1'b0;
    clear_res.seen     = '0;
    clear_res.count    = '0;
  end

  // response with the final entry count
  always_comb begin
    rsp_load       = res;
    rsp_load.count = 4'(count);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) state_next = B_START;
      end
      B_START: begin
        if (is_clear || cnt_zero) state_next = B_RESP;
        else                      state_next = B_SCAN;
      end
      B_SCAN: begin
        if (hit) begin
          if (item.op == CMD_REMOVE && more_scan) state_next = B_SHIFT;
          else                                    state_next = B_RESP;
        end else if (!more_scan) begin
          state_next = B_RESP;
        end
      end
      B_SHIFT: begin
        if (!more_shift) state_next = B_RESP;
      end
      B_RESP: begin
        if (rsp_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    q_ready    = state == B_IDLE;
    rd_en      = 1'b0;
    rd_idx     = idx;
    wr_en      = 1'b0;
    wr_idx     = idx;
    wr_data    = rd_data;
    idx_next   = idx;
    count_next = count;
    res_next   = res;
    load_rsp   = 1'b0;
    case (state)
      B_IDLE: begin
      end
      B_START: begin
        if (is_clear) begin
          count_next = '0;
          res_next   = clear_res;
        end else if (cnt_zero) begin
          res_next = miss_res;
          if (miss_append) begin
            wr_en      = 1'b1;
            wr_idx     = '0;
            wr_data    = new_entry;
            count_next = count + 1'b1;
          end
        end else begin
          rd_en    = 1'b1;
          rd_idx   = '0;
          idx_next = '0;
        end
      end
      B_SCAN: begin
        if (hit) begin
          res_next = hit_res;
          if (item.op == CMD_ADD) begin
            wr_en   = 1'b1;
            wr_data = upd_entry;
          end else if (item.op == CMD_REMOVE) begin
            if (more_scan) begin
              rd_en  = 1'b1;
              rd_idx = IDX_W'(idx_inc);
            end else begin
              count_next = count - 1'b1;
            end
          end
        end else if (!more_scan) begin
          res_next = miss_res;
          if (miss_append) begin
            wr_en      = 1'b1;
            wr_idx     = IDX_W'(count);
            wr_data    = new_entry;
            count_next = count + 1'b1;
          end
        end else begin
          rd_en    = 1'b1;
          rd_idx   = IDX_W'(idx_inc);
          idx_next = IDX_W'(idx_inc);
        end
      end
      B_SHIFT: begin
        // move the slot above down by one
        wr_en = 1'b1;
        if (more_shift) begin
          rd_en    = 1'b1;
          rd_idx   = IDX_W'(idx_inc2);
          idx_next = IDX_W'(idx_inc);
        end else begin
          count_next = count - 1'b1;
        end
      end
      B_RESP: begin
        load_rsp = rsp_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      item <= q_item;
    end
    idx <= idx_next;
    res <= res_next;
    if (load_rsp) begin
      rsp <= rsp_load;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// File: hw/rtl/peer_address_table.sv
// Peer address table: front end, two-item queue and a scanning table engine.
// Response time grows with the slots scanned (matched slot plus one, or the entry count)
// and, on remove, with the entries shifted. The engine takes one item at a time through
// the single read port of the slot memory; it takes a new item only after the last response is loaded.
// Reset (synchronous, rst high) empties the table count, queue and handshakes at once;
// slot contents are not swept, since slots at or above the count are never read.
`include "peer_address_table_defines.svh"
module peer_address_table import pat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        command,
  input  logic [47:0]       peer_address,
  input  logic signed [7:0] signal_strength,
  input  logic              host_flag,
  input  logic [31:0]       time_ms,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [1:0]        status,
  output logic              found,
  output logic signed [7:0] entry_strength,
  output logic              entry_host,
  output logic [31:0]       entry_seen,
  output logic [3:0]        entry_count
);

  logic    f_valid;
  logic    f_ready;
  item_t   f_item;
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t rsp;

  pat_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .command         (command),
    .peer_address    (peer_address),
    .signal_strength (signal_strength),
    .host_flag       (host_flag),
    .time_ms         (time_ms),
    .f_valid         (f_valid),
    .f_ready         (f_ready),
    .f_item          (f_item)
  );

  pat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  pat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // response fields
  assign status         = rsp.status;
  assign found          = rsp.found;
  assign entry_strength = rsp.strength;
  assign entry_host     = rsp.host;
  assign entry_seen     = rsp.seen;
  assign entry_count    = rsp.count;

  // checks
  `PAT_ASSERT_IMPL(a_full_only_when_full, rsp_valid && status == STAT_FULL, entry_count == 4'(DEPTH) && !found, "full reported with room left")
  `PAT_ASSERT_IMPL(a_found_is_ok, rsp_valid && found, status == STAT_OK, "match reported with error status")
  `PAT_ASSERT_IMPL(a_no_entry_fields, rsp_valid && !found && status != STAT_APPENDED, entry_strength == NO_STRENGTH && entry_seen == 32'd0 && !entry_host, "no-entry fields not defaulted")
  `PAT_ASSERT_NEXT(a_front_holds_item, cmd_valid && cmd_ready, f_valid, "accepted item lost at the front")

endmodule

// File: tb/peer_address_table_tb.sv
// Self-checking testbench for peer_address_table: directed and random command items
// against an in-bench model of the peer table, with sender gaps and response stalls.
// Depends on pat_pkg and the peer_address_table RTL only.
module peer_address_table_tb;
  import pat_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 12;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  logic [1:0]        command = CMD_CLEAR;
  logic [47:0]       peer_address = '0;
  logic signed [7:0] signal_strength = '0;
  logic              host_flag = 1'b0;
  logic [31:0]       time_ms = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic [1:0]        status;
  logic              found;
  logic signed [7:0] entry_strength;
  logic              entry_host;
  logic [31:0]       entry_seen;
  logic [3:0]        entry_count;

  peer_address_table dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .command(command), .peer_address(peer_address), .signal_strength(signal_strength),
    .host_flag(host_flag), .time_ms(time_ms),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found(found), .entry_strength(entry_strength),
    .entry_host(entry_host), .entry_seen(entry_seen), .entry_count(entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model of the table contents, only slots below peer_count are meaningful
  logic [47:0]       peer_addr_mdl[DEPTH];
  logic signed [7:0] peer_strength_mdl[DEPTH];
  logic [31:0]       peer_seen_mdl[DEPTH];
  logic              peer_host_mdl[DEPTH];
  int                peer_count;

  result_t     pending_rsp[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  logic [47:0] peer_pool[POOL_SIZE];

  // apply one command to the model table and return the response it gives
  function automatic result_t table_apply(input cmd_t op, input logic [47:0] addr,
      input logic signed [7:0] strength, input logic host, input logic [31:0] now);
    result_t r;
    int hit;
    hit = -1;
    r.status   = STAT_OK;
    r.found    = 1'b0;
    r.strength = NO_STRENGTH;
    r.host     = 1'b0;
    r.seen     = '0;
    if (op == CMD_CLEAR) begin
      peer_count = 0;
    end else begin
      // lowest matching valid slot wins
      for (int i = 0; i < peer_count; i++)
        if (hit < 0 && peer_addr_mdl[i] == addr) hit = i;
      case (op)
        CMD_ADD: begin
          if (hit >= 0) begin
            peer_strength_mdl[hit] = strength;
            peer_seen_mdl[hit]     = now;
            r.found = 1'b1;
          end else if (peer_count < DEPTH) begin
            hit = peer_count;
            peer_addr_mdl[hit]     = addr;
            peer_strength_mdl[hit] = strength;
            peer_seen_mdl[hit]     = now;
            peer_host_mdl[hit]     = host;
            peer_count++;
            r.status = STAT_APPENDED;
          end else begin
            r.status = STAT_FULL;
          end
        end
        default: begin
          if (hit < 0) r.status = STAT_NOT_FOUND;
          else r.found = 1'b1;
        end
      endcase
      if (hit >= 0) begin
        r.strength = peer_strength_mdl[hit];
        r.host     = peer_host_mdl[hit];
        r.seen     = peer_seen_mdl[hit];
      end
      // remove reports the entry, then closes the gap
      if (op == CMD_REMOVE && hit >= 0) begin
        for (int j = hit; j < peer_count - 1; j++) begin
          peer_addr_mdl[j]     = peer_addr_mdl[j + 1];
          peer_strength_mdl[j] = peer_strength_mdl[j + 1];
          peer_seen_mdl[j]     = peer_seen_mdl[j + 1];
          peer_host_mdl[j]     = peer_host_mdl[j + 1];
        end
        peer_count--;
      end
    end
    r.count = 4'(peer_count);
    return r;
  endfunction

  // offer one item, wait for its acceptance, then queue the predicted response
  task automatic issue_command(input cmd_t op, input logic [47:0] addr,
      input logic signed [7:0] strength, input logic host, input logic [31:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid       <= 1'b1;
    command         <= op;
    peer_address    <= addr;
    signal_strength <= strength;
    host_flag       <= host;
    time_ms         <= now;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_rsp.push_back(table_apply(op, addr, strength, host, now));
  endtask

  function automatic logic [47:0] random_address();
    return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
  endfunction

  // mostly addresses from the pool so adds, hits and removes meet each other
  function automatic logic [47:0] pick_address();
    if ($urandom_range(99) < 7) return random_address();
    return peer_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic issue_random_item();
    int   pick;
    cmd_t op;
    pick = $urandom_range(99);
    if (pick < 48) op = CMD_ADD;
    else if (pick < 68) op = CMD_REMOVE;
    else if (pick < 97) op = CMD_LOOKUP;
    else op = CMD_CLEAR;
    issue_command(op, pick_address(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  32'($urandom));
  endtask

  // edge values, every command, full table and removal from the first, a middle and the last position
  task automatic test_directed_cases();
    logic [47:0] ones;
    ones = '1;
    sender_idle_pct = 0;
    receiver_stall_pct <= 0;
    issue_command(CMD_CLEAR, '0, '0, 1'b0, '0);
    issue_command(CMD_LOOKUP, '0, '0, 1'b0, '0);
    issue_command(CMD_REMOVE, '0, '0, 1'b0, '0);
    issue_command(CMD_ADD, '0, -8'sd128, 1'b0, '0);
    issue_command(CMD_ADD, ones, 8'sd127, 1'b1, '1);
    // update keeps the stored host flag
    issue_command(CMD_ADD, '0, 8'sd5, 1'b1, 32'd123);
    issue_command(CMD_LOOKUP, ones, '0, 1'b0, '0);
    for (int i = 1; i <= 6; i++)
      issue_command(CMD_ADD, 48'h0000_1000_0000 * i + 48'hA5, 8'(-10 * i), 1'(i & 1),
                    32'h1000 * i);
    // full table: new address refused, existing one still updates
    issue_command(CMD_ADD, 48'h5555_AAAA_5555, 8'sd1, 1'b1, 32'd77);
    issue_command(CMD_ADD, ones, -8'sd1, 1'b0, 32'hDEAD_BEEF);
    issue_command(CMD_LOOKUP, 48'h8000_0000_0000, '0, 1'b0, '0);
    issue_command(CMD_REMOVE, 48'h0000_2000_00A5, '0, 1'b0, '0);
    issue_command(CMD_REMOVE, 48'h0000_6000_00A5, '0, 1'b0, '0);
    issue_command(CMD_REMOVE, '0, '0, 1'b0, '0);
    issue_command(CMD_LOOKUP, '0, '0, 1'b0, '0);
    issue_command(CMD_ADD, 48'h1234_5678_9ABC, 8'sd42, 1'b1, 32'd999);
    issue_command(CMD_CLEAR, ones, '1, 1'b1, '1);
    issue_command(CMD_LOOKUP, ones, '0, 1'b0, '0);
  endtask

  // random commands over a fresh address pool with given idling on each side
  task automatic test_random_mix(input int n, input int idle_pct, input int stall_pct);
    for (int i = 0; i < POOL_SIZE; i++) peer_pool[i] = random_address();
    sender_idle_pct = idle_pct;
    receiver_stall_pct <= stall_pct;
    repeat (n) issue_random_item();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering items
  task automatic test_rsp_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    repeat (20) issue_random_item();
  endtask

  // response ready: long hold when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [47:0] want,
      input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each accepted response with the oldest prediction
  always @(posedge clk) begin : check_rsp
    result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none expected, status %0h count %0h",
                 $time, status, entry_count);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, status);
        check_field("found", want.found, found);
        check_field("entry_strength", want.strength, entry_strength);
        check_field("entry_host", want.host, entry_host);
        check_field("entry_seen", want.seen, entry_seen);
        check_field("entry_count", want.count, entry_count);
      end
    end
  end

  initial begin
    peer_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_mix(250, 0, 0);
    test_random_mix(230, 77, 0);
    test_rsp_backpressure();
    test_random_mix(230, 0, 77);
    test_random_mix(230, 36, 36);
    // drain, then leave room for anything still in flight
    cmd_valid <= 1'b0;
    @(posedge clk);
    receiver_stall_pct <= 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_rsp.size() == 0 && mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
